// File: rtl/core/rgbhsv_pkg.sv
// Shared constants, types and codes for the RGB to HSV pixel converter.
package rgbhsv_pkg;

    localparam int unsigned COMPONENT_BITS = 8;
    localparam int unsigned HUE_W          = 15;
    localparam int unsigned HUE_FRAC_W     = 12;
    localparam int unsigned HUE_SIXTH      = 3840;
    localparam int unsigned HUE_FULL       = 23040;

    localparam int unsigned Q_RAW      = (COMPONENT_BITS > HUE_FRAC_W) ? COMPONENT_BITS
                                                                         : HUE_FRAC_W;
    localparam int unsigned DIV_STAGES = (Q_RAW + 1) / 2;
    localparam int unsigned Q_W        = 2 * DIV_STAGES;
    localparam int unsigned NUM_W      = COMPONENT_BITS + Q_W;

    localparam logic [COMPONENT_BITS-1:0] FULL = {COMPONENT_BITS{1'b1}};

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] rem;
        logic [Q_W-1:0]            quo;
    } div_t;

    typedef struct packed {
        logic [COMPONENT_BITS-1:0] mx;
        logic [COMPONENT_BITS-1:0] delta;
        sector_t                   sector;
        logic                      neg;
        logic [COMPONENT_BITS-1:0] alpha;
        div_t                      sat_div;
        div_t                      hue_div;
    } pix_t;

    typedef struct packed {
        logic [HUE_W-1:0]          hue;
        logic                      undef;
        logic [COMPONENT_BITS-1:0] sat;
        logic [COMPONENT_BITS-1:0] bright;
        logic [COMPONENT_BITS-1:0] alpha;
    } hsv_t;

endpackage

// File: rtl/core/rgbhsv_front.sv
// Front stages: max, min, hue sector and the two dividend products.
module rgbhsv_front
    import rgbhsv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      pix_valid,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    input  logic [COMPONENT_BITS-1:0] alpha,
    output logic                      out_valid,
    output pix_t                      out_pix
);

    logic                      a_valid_reg;
    logic [COMPONENT_BITS-1:0] a_mx_reg, a_mn_reg, a_diff_reg, a_alpha_reg;
    sector_t                   a_sector_reg;
    logic                      a_neg_reg;

    logic [COMPONENT_BITS-1:0] mx_next, mn_next, diff_next;
    sector_t                   sector_next;
    logic                      neg_next;

    logic                      b_valid_reg;
    pix_t                      b_pix_reg;
    pix_t                      b_pix_next;

    logic [COMPONENT_BITS-1:0] delta;
    logic [NUM_W-1:0]          num_sat, num_hue;

    always_comb
    begin
        mx_next = red;
        if (green > mx_next)
        begin
            mx_next = green;
        end
        if (blue > mx_next)
        begin
            mx_next = blue;
        end
        mn_next = red;
        if (green < mn_next)
        begin
            mn_next = green;
        end
        if (blue < mn_next)
        begin
            mn_next = blue;
        end

        if (red == mx_next)
        begin
            sector_next = SEC_RED;
        end
        else if (green == mx_next)
        begin
            sector_next = SEC_GREEN;
        end
        else
        begin
            sector_next = SEC_BLUE;
        end

        case (sector_next)
            SEC_RED:
            begin
                neg_next  = green < blue;
                diff_next = neg_next ? blue - green : green - blue;
            end
            SEC_GREEN:
            begin
                neg_next  = blue < red;
                diff_next = neg_next ? red - blue : blue - red;
            end
            default:
            begin
                neg_next  = red < green;
                diff_next = neg_next ? green - red : red - green;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= pix_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_mx_reg     <= mx_next;
            a_mn_reg     <= mn_next;
            a_diff_reg   <= diff_next;
            a_alpha_reg  <= alpha;
            a_sector_reg <= sector_next;
            a_neg_reg    <= neg_next;
            b_pix_reg    <= b_pix_next;
        end
    end

    always_comb
    begin
        delta   = a_mx_reg - a_mn_reg;
        num_sat = NUM_W'(FULL) * NUM_W'(delta);
        num_hue = NUM_W'(HUE_SIXTH) * NUM_W'(a_diff_reg);

        b_pix_next             = '0;
        b_pix_next.mx          = a_mx_reg;
        b_pix_next.delta       = delta;
        b_pix_next.sector      = a_sector_reg;
        b_pix_next.neg         = a_neg_reg;
        b_pix_next.alpha       = a_alpha_reg;
        b_pix_next.sat_div.rem = num_sat[NUM_W-1:Q_W];
        b_pix_next.sat_div.quo = num_sat[Q_W-1:0];
        b_pix_next.hue_div.rem = num_hue[NUM_W-1:Q_W];
        b_pix_next.hue_div.quo = num_hue[Q_W-1:0];
    end

    assign out_valid = b_valid_reg;
    assign out_pix   = b_pix_reg;

endmodule

// File: rtl/core/rgbhsv_div_stage.sv
// One divider stage: two restoring steps on both the saturation and hue quotients.
module rgbhsv_div_stage
    import rgbhsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic adv,
    input  logic in_valid,
    input  pix_t in_pix,
    output logic out_valid,
    output pix_t out_pix
);

    logic valid_reg;
    pix_t pix_reg;
    pix_t pix_next;

    function automatic div_t div_step(input div_t d, input logic [COMPONENT_BITS-1:0] den);
        logic [COMPONENT_BITS:0] t;
        logic                    bit_q;
        div_t                    r;
        t     = {d.rem, d.quo[Q_W-1]};
        bit_q = t >= {1'b0, den};
        if (bit_q)
        begin
            t = t - {1'b0, den};
        end
        r.rem = t[COMPONENT_BITS-1:0];
        r.quo = {d.quo[Q_W-2:0], bit_q};
        return r;
    endfunction

    always_comb
    begin
        pix_next         = in_pix;
        pix_next.sat_div = div_step(div_step(in_pix.sat_div, in_pix.mx), in_pix.mx);
        pix_next.hue_div = div_step(div_step(in_pix.hue_div, in_pix.delta), in_pix.delta);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule

// File: rtl/core/rgbhsv_back.sv
// Hue assembly, output register and skid stage.
module rgbhsv_back
    import rgbhsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  pix_t in_pix,
    input  logic hsv_stall,
    output logic hsv_valid,
    output hsv_t hsv,
    output logic adv
);

    logic             out_valid_reg, skid_valid_reg;
    hsv_t             out_reg, skid_reg;
    hsv_t             res;
    logic [HUE_W-1:0] base, base_neg, frac, ceil_q;
    logic             take;

    always_comb
    begin
        case (in_pix.sector)
            SEC_RED:
            begin
                base     = '0;
                base_neg = HUE_W'(HUE_FULL);
            end
            SEC_GREEN:
            begin
                base     = HUE_W'(2 * HUE_SIXTH);
                base_neg = HUE_W'(2 * HUE_SIXTH);
            end
            default:
            begin
                base     = HUE_W'(4 * HUE_SIXTH);
                base_neg = HUE_W'(4 * HUE_SIXTH);
            end
        endcase

        frac   = HUE_W'(in_pix.hue_div.quo[HUE_FRAC_W-1:0]);
        ceil_q = frac + HUE_W'(in_pix.hue_div.rem != '0);

        res.undef  = in_pix.delta == '0;
        res.bright = in_pix.mx;
        res.alpha  = in_pix.alpha;
        res.sat    = (in_pix.mx == '0) ? '0 : in_pix.sat_div.quo[COMPONENT_BITS-1:0];
        if (res.undef)
        begin
            res.hue = '0;
        end
        else if (in_pix.neg)
        begin
            res.hue = base_neg - ceil_q;
        end
        else
        begin
            res.hue = base + frac;
        end
    end

    assign adv  = !skid_valid_reg;
    assign take = !out_valid_reg || !hsv_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (adv && in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (adv && in_valid)
        begin
            skid_reg <= res;
        end
    end

    assign hsv_valid = out_valid_reg;
    assign hsv       = out_reg;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !hsv_stall |=> !skid_valid_reg && out_valid_reg)
        else $error("skid word not moved to output");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.undef |-> out_reg.hue == '0 && out_reg.sat == '0)
        else $error("grey word with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.hue < HUE_W'(HUE_FULL))
        else $error("hue out of range");

endmodule

// File: rtl/core/rgb_to_hsv_pixel_top.sv
// Top level of the RGB to HSV pixel converter.
//
//  channel | valid     | stall     | payload
//  pixel   | pix_valid | pix_stall | red, green, blue, alpha
//  hsv     | hsv_valid | hsv_stall | hue, hue_undefined, saturation, brightness, alpha_out
//
// One word accepted per cycle while pix_stall is low; 2 front stages, 6 divider
// stages (2 quotient bits each for saturation and hue) and 1 output register.
// rst_n clears all valid bits asynchronously; payload registers hold no reset.
// A stall on hsv parks one word in the skid stage; pix_stall then rises the
// next cycle and the whole pipeline holds until the skid word drains.
module rgb_to_hsv_pixel_top
    import rgbhsv_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    output logic                      pix_stall,
    input  logic [COMPONENT_BITS-1:0] red,
    input  logic [COMPONENT_BITS-1:0] green,
    input  logic [COMPONENT_BITS-1:0] blue,
    input  logic [COMPONENT_BITS-1:0] alpha,
    output logic                      hsv_valid,
    input  logic                      hsv_stall,
    output logic [HUE_W-1:0]          hue,
    output logic                      hue_undefined,
    output logic [COMPONENT_BITS-1:0] saturation,
    output logic [COMPONENT_BITS-1:0] brightness,
    output logic [COMPONENT_BITS-1:0] alpha_out
);

    logic adv;
    logic div_valid [0:DIV_STAGES];
    pix_t div_pix   [0:DIV_STAGES];
    hsv_t hsv;

    rgbhsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .pix_valid (pix_valid),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .alpha     (alpha),
        .out_valid (div_valid[0]),
        .out_pix   (div_pix[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rgbhsv_div_stage u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (div_valid[i]),
            .in_pix    (div_pix[i]),
            .out_valid (div_valid[i+1]),
            .out_pix   (div_pix[i+1])
        );
    end

    rgbhsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid[DIV_STAGES]),
        .in_pix    (div_pix[DIV_STAGES]),
        .hsv_stall (hsv_stall),
        .hsv_valid (hsv_valid),
        .hsv       (hsv),
        .adv       (adv)
    );

    assign pix_stall     = !adv;
    assign hue           = hsv.hue;
    assign hue_undefined = hsv.undef;
    assign saturation    = hsv.sat;
    assign brightness    = hsv.bright;
    assign alpha_out     = hsv.alpha;

endmodule

// File: dv/rgb_to_hsv_pixel_top_tb.sv
// Self-checking testbench for the RGB to HSV pixel converter with its own conversion predictor.
`timescale 1ns / 1ps

module rgb_to_hsv_pixel_top_tb;
    import rgbhsv_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_PIXELS  = 1250;
    localparam int TAIL_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [COMPONENT_BITS-1:0] comp_t;

    typedef struct {
        comp_t r;
        comp_t g;
        comp_t b;
        comp_t a;
        bit    typed;
        hsv_t  want;
    } pixel_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      pix_valid = 1'b0;
    logic                      pix_stall;
    comp_t                     red = '0;
    comp_t                     green = '0;
    comp_t                     blue = '0;
    comp_t                     alpha = '0;
    logic                      hsv_valid;
    logic                      hsv_stall = 1'b0;
    logic [HUE_W-1:0]          hue;
    logic                      hue_undefined;
    logic [COMPONENT_BITS-1:0] saturation;
    logic [COMPONENT_BITS-1:0] brightness;
    logic [COMPONENT_BITS-1:0] alpha_out;

    hsv_t       hsv_expect_q[$];
    pixel_row_t pixel_rows[$];
    int         mismatch_count = 0;
    int         quiet_cycles = 0;
    int         idle_pct = 37;
    int         stall_pct = 37;

    rgb_to_hsv_pixel_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .hsv_valid     (hsv_valid),
        .hsv_stall     (hsv_stall),
        .hue           (hue),
        .hue_undefined (hue_undefined),
        .saturation    (saturation),
        .brightness    (brightness),
        .alpha_out     (alpha_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic hsv_t hsv_of_pixel(comp_t r, comp_t g, comp_t b, comp_t a);
        int   ri;
        int   gi;
        int   bi;
        int   mx;
        int   mn;
        int   delta;
        int   num;
        int   base;
        int   quo;
        int   h;
        int   sixth;
        hsv_t res;
        ri    = int'(r);
        gi    = int'(g);
        bi    = int'(b);
        sixth = int'(HUE_SIXTH);
        mx    = ri;
        mn    = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta      = mx - mn;
        res.bright = comp_t'(mx);
        res.alpha  = a;
        res.sat    = (mx != 0) ? comp_t'((int'(FULL) * delta) / mx) : '0;
        if (delta == 0)
        begin
            res.undef = 1'b1;
            res.hue   = '0;
        end
        else
        begin
            if (ri == mx)
            begin
                base = 0;
                num  = gi - bi;
            end
            else if (gi == mx)
            begin
                base = 2 * sixth;
                num  = bi - ri;
            end
            else
            begin
                base = 4 * sixth;
                num  = ri - gi;
            end
            num = num * sixth;
            quo = num / delta;
            if (num < 0 && (num % delta) != 0)
                quo = quo - 1;
            h = base + quo;
            if (h < 0)
                h = h + int'(HUE_FULL);
            res.undef = 1'b0;
            res.hue   = h[HUE_W-1:0];
        end
        return res;
    endfunction

    task automatic add_row(comp_t r, comp_t g, comp_t b, comp_t a, bit typed,
                           int h, bit undef, int sat, int bright);
        pixel_row_t row;
        row.r           = r;
        row.g           = g;
        row.b           = b;
        row.a           = a;
        row.typed       = typed;
        row.want.hue    = h[HUE_W-1:0];
        row.want.undef  = undef;
        row.want.sat    = comp_t'(sat);
        row.want.bright = comp_t'(bright);
        row.want.alpha  = a;
        pixel_rows.push_back(row);
    endtask

    task automatic send_pixel(comp_t r, comp_t g, comp_t b, comp_t a, bit typed, hsv_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            pix_valid = 1'b0;
            @(negedge clk);
        end
        red       = r;
        green     = g;
        blue      = b;
        alpha     = a;
        pix_valid = 1'b1;
        do @(posedge clk); while (pix_stall);
        hsv_expect_q.push_back(typed ? want : hsv_of_pixel(r, g, b, a));
        @(negedge clk);
    endtask

    task automatic drain_results();
        pix_valid = 1'b0;
        while (hsv_expect_q.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
        hsv_stall = ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        hsv_t want;
        bit   bad;
        if (rst_n && hsv_valid && !hsv_stall)
        begin
            if (hsv_expect_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("%0t: unexpected hsv word hue=%0d undef=%0b sat=%0d bright=%0d alpha=%0d",
                             $realtime, hue, hue_undefined, saturation, brightness, alpha_out);
            end
            else
            begin
                want = hsv_expect_q.pop_front();
                bad  = (hue !== want.hue) || (hue_undefined !== want.undef) ||
                       (saturation !== want.sat) || (brightness !== want.bright) ||
                       (alpha_out !== want.alpha);
                if (bad)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: exp hue=%0d undef=%0b sat=%0d bright=%0d alpha=%0d",
                                 $realtime, want.hue, want.undef, want.sat, want.bright,
                                 want.alpha);
                        $display("%0t: got hue=%0d undef=%0b sat=%0d bright=%0d alpha=%0d",
                                 $realtime, hue, hue_undefined, saturation, brightness,
                                 alpha_out);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (hsv_valid && !hsv_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL rgb_to_hsv_pixel_top");
            $finish;
        end
    end

    initial
    begin
        int    i;
        int    kind;
        int    pick;
        comp_t r;
        comp_t g;
        comp_t b;
        comp_t a;
        comp_t top;
        hsv_t  none;

        none = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // black, white and mid grey
        add_row(8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 0,     1'b1, 0,   0);
        add_row(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 0,     1'b1, 0,   255);
        add_row(8'd128, 8'd128, 8'd128, 8'h5A,  1'b1, 0,     1'b1, 0,   128);
        // primaries and secondaries
        add_row(8'd255, 8'd0,   8'd0,   8'hA5,  1'b1, 0,     1'b0, 255, 255);
        add_row(8'd0,   8'd255, 8'd0,   8'h0F,  1'b1, 7680,  1'b0, 255, 255);
        add_row(8'd0,   8'd0,   8'd255, 8'hF0,  1'b1, 15360, 1'b0, 255, 255);
        add_row(8'd255, 8'd255, 8'd0,   8'h55,  1'b1, 3840,  1'b0, 255, 255);
        add_row(8'd0,   8'd255, 8'd255, 8'hAA,  1'b1, 11520, 1'b0, 255, 255);
        add_row(8'd255, 8'd0,   8'd255, 8'h01,  1'b1, 19200, 1'b0, 255, 255);
        // smallest deltas, wrap of a negative red hue, ties on the largest component
        add_row(8'd1,   8'd0,   8'd0,   8'h80,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd255, 8'd0,   8'd1,   8'h7F,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd255, 8'd254, 8'd0,   8'hFE,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd128, 8'd128, 8'd127, 8'h33,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd0,   8'd1,   8'd1,   8'hCC,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd10,  8'd200, 8'd200, 8'h3C,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd200, 8'd10,  8'd200, 8'hC3,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd85,  8'd170, 8'd255, 8'h96,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd200, 8'd100, 8'd50,  8'h69,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd50,  8'd100, 8'd200, 8'h12,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd100, 8'd50,  8'd200, 8'hED,  1'b0, 0, 1'b0, 0, 0);
        add_row(8'd3,   8'd2,   8'd1,   8'h00,  1'b0, 0, 1'b0, 0, 0);

        foreach (pixel_rows[k])
            send_pixel(pixel_rows[k].r, pixel_rows[k].g, pixel_rows[k].b, pixel_rows[k].a,
                       pixel_rows[k].typed, pixel_rows[k].want);
        drain_results();

        for (i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == 500)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            if (i == 800)
            begin
                idle_pct  = 37;
                stall_pct = 37;
            end
            if (i == 900)
                drain_results();
            kind = $urandom_range(9);
            a    = comp_t'($urandom_range(255));
            r    = comp_t'($urandom_range(255));
            g    = comp_t'($urandom_range(255));
            b    = comp_t'($urandom_range(255));
            if (kind == 0)
            begin
                g = r;
                b = r;
            end
            else if (kind == 1)
            begin
                top  = comp_t'($urandom_range(255));
                pick = $urandom_range(2);
                r    = (pick == 2) ? comp_t'($urandom_range(top)) : top;
                g    = (pick == 1) ? comp_t'($urandom_range(top)) : top;
                b    = (pick == 0) ? comp_t'($urandom_range(top)) : top;
            end
            else if (kind == 2)
            begin
                pick = $urandom_range(8);
                if (pick % 3 == 0) r = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                if (pick % 3 == 1) g = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                if (pick % 3 == 2) b = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
                if (pick > 5) a = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
            end
            send_pixel(r, g, b, a, 1'b0, none);
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("PASS rgb_to_hsv_pixel_top");
        else
            $display("FAIL rgb_to_hsv_pixel_top");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_front.sv
rtl/core/rgbhsv_div_stage.sv
rtl/core/rgbhsv_back.sv
rtl/core/rgb_to_hsv_pixel_top.sv
dv/rgb_to_hsv_pixel_top_tb.sv
